>>> hdl/lxrg_pkg.sv
// Types, constants and control store for the lagged XOR random generator.
`timescale 1ns / 1ps
`default_nettype none
package lxrg_pkg;

  // Table geometry and datapath widths
  localparam int TABLE_DEPTH = 256;
  localparam int PTR_W       = 8;
  localparam int WORD_W      = 31;
  localparam int PM_PROD_W   = 46;
  localparam int DRAW_PROD_W = 62;

  // Lag taps behind the write position
  localparam logic [PTR_W-1:0] TAP_NEAR = 8'd103;
  localparam logic [PTR_W-1:0] TAP_FAR  = 8'd250;

  // Park-Miller constants
  localparam logic [14:0]       PM_MULT    = 15'd16807;
  localparam logic [31:0]       PM_MOD     = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] SEED_RESET = 31'd12345;

  // Request kinds
  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_RESEED = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] range_max;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] scaled;
  } rsp_t;

  // Microcode fields
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_DISPATCH,
    JMP_IF_ZERO,
    JMP_LOOP,
    JMP_WAIT_OUT
  } jmp_t;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_CLEAR,
    PTR_INC
  } ptr_op_t;

  typedef enum logic [1:0] {
    PM_HOLD,
    PM_LOAD,
    PM_MUL,
    PM_FOLD
  } pm_op_t;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_DISCARD,
    CNT_FILL,
    CNT_WARM,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_LAG,
    WR_FILL
  } wr_op_t;

  typedef logic [3:0] upc_t;

  typedef struct packed {
    jmp_t    jmp;
    upc_t    target;
    ptr_op_t ptr_op;
    pm_op_t  pm_op;
    cnt_op_t cnt_op;
    wr_op_t  wr_op;
    logic    rd_en;
    logic    mul_en;
    logic    out_load;
    logic    req_ready;
  } uword_t;

  // Control store addresses
  localparam upc_t UPC_FETCH     = 4'd0;
  localparam upc_t UPC_DRAW_RD   = 4'd1;
  localparam upc_t UPC_DRAW_WR   = 4'd2;
  localparam upc_t UPC_DRAW_MUL  = 4'd3;
  localparam upc_t UPC_DRAW_OUT  = 4'd4;
  localparam upc_t UPC_RESEED    = 4'd5;
  localparam upc_t UPC_SKIP_CHK  = 4'd6;
  localparam upc_t UPC_DISC_MUL  = 4'd7;
  localparam upc_t UPC_DISC_FOLD = 4'd8;
  localparam upc_t UPC_FILL_INIT = 4'd9;
  localparam upc_t UPC_FILL_MUL  = 4'd10;
  localparam upc_t UPC_FILL_FOLD = 4'd11;
  localparam upc_t UPC_WARM_INIT = 4'd12;
  localparam upc_t UPC_WARM_RD   = 4'd13;
  localparam upc_t UPC_WARM_WR   = 4'd14;
  localparam upc_t UPC_DONE      = 4'd15;

  // Pack one control word
  function automatic uword_t uw(jmp_t j, upc_t t, ptr_op_t p, pm_op_t m, cnt_op_t c,
                                wr_op_t w, logic rd, logic mul, logic ol, logic rdy);
    uword_t r;
    r.jmp       = j;
    r.target    = t;
    r.ptr_op    = p;
    r.pm_op     = m;
    r.cnt_op    = c;
    r.wr_op     = w;
    r.rd_en     = rd;
    r.mul_en    = mul;
    r.out_load  = ol;
    r.req_ready = rdy;
    return r;
  endfunction

  // Control store: draw path, then reseed (discard, fill, warm-up)
  function automatic uword_t ucode_rom(upc_t a);
    uword_t r;
    unique case (a)
      UPC_FETCH:     r = uw(JMP_DISPATCH, UPC_DRAW_RD, PTR_HOLD, PM_HOLD, CNT_HOLD,
                            WR_NONE, 1'b0, 1'b0, 1'b0, 1'b1);
      UPC_DRAW_RD:   r = uw(JMP_NEXT, UPC_FETCH, PTR_HOLD, PM_HOLD, CNT_HOLD,
                            WR_NONE, 1'b1, 1'b0, 1'b0, 1'b0);
      UPC_DRAW_WR:   r = uw(JMP_NEXT, UPC_FETCH, PTR_INC, PM_HOLD, CNT_HOLD,
                            WR_LAG, 1'b0, 1'b0, 1'b0, 1'b0);
      UPC_DRAW_MUL:  r = uw(JMP_NEXT, UPC_FETCH, PTR_HOLD, PM_HOLD, CNT_HOLD,
                            WR_NONE, 1'b0, 1'b1, 1'b0, 1'b0);
      UPC_DRAW_OUT:  r = uw(JMP_WAIT_OUT, UPC_FETCH, PTR_HOLD, PM_HOLD, CNT_HOLD,
                            WR_NONE, 1'b0, 1'b0, 1'b1, 1'b0);
      UPC_RESEED:    r = uw(JMP_NEXT, UPC_FETCH, PTR_HOLD, PM_LOAD, CNT_DISCARD,
                            WR_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
      UPC_SKIP_CHK:  r = uw(JMP_IF_ZERO, UPC_FILL_INIT, PTR_HOLD, PM_HOLD, CNT_HOLD,
                            WR_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
      UPC_DISC_MUL:  r = uw(JMP_NEXT, UPC_FETCH, PTR_HOLD, PM_MUL, CNT_HOLD,
                            WR_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
      UPC_DISC_FOLD: r = uw(JMP_LOOP, UPC_DISC_MUL, PTR_HOLD, PM_FOLD, CNT_DEC,
                            WR_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
      UPC_FILL_INIT: r = uw(JMP_NEXT, UPC_FETCH, PTR_CLEAR, PM_HOLD, CNT_FILL,
                            WR_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
      UPC_FILL_MUL:  r = uw(JMP_NEXT, UPC_FETCH, PTR_HOLD, PM_MUL, CNT_HOLD,
                            WR_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
      UPC_FILL_FOLD: r = uw(JMP_LOOP, UPC_FILL_MUL, PTR_INC, PM_FOLD, CNT_DEC,
                            WR_FILL, 1'b0, 1'b0, 1'b0, 1'b0);
      UPC_WARM_INIT: r = uw(JMP_NEXT, UPC_FETCH, PTR_HOLD, PM_HOLD, CNT_WARM,
                            WR_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
      UPC_WARM_RD:   r = uw(JMP_NEXT, UPC_FETCH, PTR_HOLD, PM_HOLD, CNT_HOLD,
                            WR_NONE, 1'b1, 1'b0, 1'b0, 1'b0);
      UPC_WARM_WR:   r = uw(JMP_LOOP, UPC_WARM_RD, PTR_INC, PM_HOLD, CNT_DEC,
                            WR_LAG, 1'b0, 1'b0, 1'b0, 1'b0);
      UPC_DONE:      r = uw(JMP_ALWAYS, UPC_FETCH, PTR_HOLD, PM_HOLD, CNT_HOLD,
                            WR_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
      default:       r = uw(JMP_ALWAYS, UPC_FETCH, PTR_HOLD, PM_HOLD, CNT_HOLD,
                            WR_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/lagged_xor_random_generator_core.sv
// Lagged XOR random generator: microcoded sequencer, lag table and output register.
// Draw: after the request transfer the control store runs its read, write, multiply and
//   load steps; load waits for a free output register, then the next request is taken.
// Reseed (no result): WARMUP_STEPS - 1 Park-Miller steps discarded, TABLE_DEPTH fill
//   the table, WARMUP_STEPS + 1 table XOR steps follow. Output register still drains.
// Reset (synchronous, rst high) clears the table valid bits, so the table reads as
//   zeros, zeroes the pointer and sets seed to 12345.
`timescale 1ns / 1ps
`default_nettype none
module lagged_xor_random_generator_core #(
  parameter int WARMUP_STEPS = 10000
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               req_valid,
  output logic              req_ready,
  input  lxrg_pkg::req_t    req,
  output logic              rsp_valid,
  input  wire               rsp_ready,
  output lxrg_pkg::rsp_t    rsp,
  input  wire               seed_we,
  input  wire  [30:0]       seed_wdata
);
  import lxrg_pkg::*;

  localparam int CNT_MAX = (WARMUP_STEPS + 1 > TABLE_DEPTH) ? WARMUP_STEPS + 1 : TABLE_DEPTH;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  // Sequencer
  upc_t   upc;
  upc_t   upc_next;
  uword_t cw;

  // Registers
  logic [CNT_W-1:0]       cnt;
  logic [PTR_W-1:0]       ptr;
  logic [WORD_W-1:0]      seed;
  logic [WORD_W-1:0]      pm_x;
  logic [PM_PROD_W-1:0]   pm_prod;
  logic [WORD_W-1:0]      range_q;
  logic [WORD_W-1:0]      value_q;
  logic [DRAW_PROD_W-1:0] draw_prod;

  // Table
  logic [WORD_W-1:0]      lag_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] mem_vld;
  logic [WORD_W-1:0]      near_q;
  logic [WORD_W-1:0]      far_q;
  logic                   near_vld;
  logic                   far_vld;

  // Combinational
  logic                   req_acc;
  logic                   out_free;
  logic                   out_load;
  logic [PTR_W-1:0]       ptr_inc;
  logic [PTR_W-1:0]       addr_near;
  logic [PTR_W-1:0]       addr_far;
  logic [PTR_W-1:0]       wr_addr;
  logic [WORD_W-1:0]      wr_data;
  logic                   mem_we;
  logic [WORD_W-1:0]      lag_word;
  logic [31:0]            pm_sum;
  logic [WORD_W-1:0]      pm_fold;

  // Decode current control word
  assign cw        = ucode_rom(upc);
  assign req_ready = cw.req_ready;
  assign req_acc   = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;
  assign out_load  = cw.out_load && out_free;

  // Next microaddress
  always_comb begin
    upc_next = upc + 4'd1;
    unique case (cw.jmp)
      JMP_NEXT: begin
        upc_next = upc + 4'd1;
      end
      JMP_ALWAYS: begin
        upc_next = cw.target;
      end
      JMP_DISPATCH: begin
        if (!req_valid) begin
          upc_next = upc;
        end else if (req.kind == KIND_RESEED) begin
          upc_next = UPC_RESEED;
        end else begin
          upc_next = cw.target;
        end
      end
      JMP_IF_ZERO: begin
        if (cnt == '0) upc_next = cw.target;
      end
      JMP_LOOP: begin
        if (cnt != CNT_W'(1)) upc_next = cw.target;
      end
      JMP_WAIT_OUT: begin
        upc_next = out_free ? cw.target : upc;
      end
      default: begin
        upc_next = UPC_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  // Tap addresses and table write selection
  assign ptr_inc   = ptr + 8'd1;
  assign addr_near = ptr_inc - TAP_NEAR;
  assign addr_far  = ptr_inc - TAP_FAR;
  assign lag_word  = (near_vld ? near_q : '0) ^ (far_vld ? far_q : '0);
  assign mem_we    = (cw.wr_op != WR_NONE);
  assign wr_addr   = (cw.wr_op == WR_FILL) ? ptr : ptr_inc;
  assign wr_data   = (cw.wr_op == WR_FILL) ? pm_fold : lag_word;

  // Park-Miller fold: low 31 bits plus high part, one conditional subtract
  assign pm_sum  = {1'b0, pm_prod[WORD_W-1:0]} + 32'(pm_prod[PM_PROD_W-1:WORD_W]);
  assign pm_fold = pm_sum[31] ? 31'(pm_sum - PM_MOD) : pm_sum[WORD_W-1:0];

  // Table storage with registered tap reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      lag_mem[wr_addr] <= wr_data;
    end
    if (cw.rd_en) begin
      near_q <= lag_mem[addr_near];
      far_q  <= lag_mem[addr_far];
    end
  end

  // Track written entries; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld  <= '0;
      near_vld <= 1'b0;
      far_vld  <= 1'b0;
    end else begin
      if (mem_we) mem_vld[wr_addr] <= 1'b1;
      if (cw.rd_en) begin
        near_vld <= mem_vld[addr_near];
        far_vld  <= mem_vld[addr_far];
      end
    end
  end

  // Pointer, loop counter, seed and Park-Miller state
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      cnt  <= '0;
      seed <= SEED_RESET;
      pm_x <= '0;
    end else begin
      unique case (cw.ptr_op)
        PTR_CLEAR: ptr <= '0;
        PTR_INC:   ptr <= ptr_inc;
        default:   ptr <= ptr;
      endcase
      unique case (cw.cnt_op)
        CNT_DISCARD: cnt <= CNT_W'(WARMUP_STEPS - 1);
        CNT_FILL:    cnt <= CNT_W'(TABLE_DEPTH);
        CNT_WARM:    cnt <= CNT_W'(WARMUP_STEPS + 1);
        CNT_DEC:     cnt <= cnt - CNT_W'(1);
        default:     cnt <= cnt;
      endcase
      if (seed_we) seed <= seed_wdata;
      unique case (cw.pm_op)
        PM_LOAD: pm_x <= seed;
        PM_FOLD: pm_x <= pm_fold;
        default: pm_x <= pm_x;
      endcase
    end
  end

  // Datapath payload registers
  always_ff @(posedge clk) begin
    if (cw.pm_op == PM_MUL) pm_prod <= PM_PROD_W'(pm_x) * PM_PROD_W'(PM_MULT);
    if (req_acc) range_q <= req.range_max;
    if (cw.wr_op == WR_LAG) value_q <= lag_word;
    if (cw.mul_en) draw_prod <= DRAW_PROD_W'(value_q) * DRAW_PROD_W'(range_q);
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.value  <= value_q;
      rsp.scaled <= draw_prod[DRAW_PROD_W-1:WORD_W];
    end
  end

  // Checks
  a_draw_starts: assert property (@(posedge clk) disable iff (rst)
    req_acc && (req.kind == KIND_DRAW) |=> upc == UPC_DRAW_RD)
    else $error("draw transfer did not start the draw sequence");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && cw.rd_en))
    else $error("table write and tap read in the same cycle");

  a_rsp_from_draw: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(upc) == UPC_DRAW_OUT)
    else $error("result raised outside the draw output step");

  a_cnt_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (cw.cnt_op == CNT_DEC) |-> (cnt != '0))
    else $error("loop counter decremented from zero");

endmodule
`default_nettype wire

>>> sim/lxrg_checker.sv
// Transfer monitor, draw predictor and result comparison for the lagged XOR generator.
`timescale 1ns / 1ps
module lxrg_checker #(
  parameter int WARMUP_STEPS = 10000
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             req_valid,
  input  wire             req_ready,
  input  lxrg_pkg::req_t  req,
  input  wire             rsp_valid,
  input  wire             rsp_ready,
  input  lxrg_pkg::rsp_t  rsp,
  input  wire             seed_we,
  input  wire  [30:0]     seed_wdata,
  output int              mismatches,
  output int              pending
);
  import lxrg_pkg::*;

  // Predicted generator state
  logic [WORD_W-1:0] lag_words [TABLE_DEPTH];
  logic [PTR_W-1:0]  write_pos;
  logic [WORD_W-1:0] seed_value;

  // Draw results not yet seen on the output channel, oldest first
  rsp_t expected_draws [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("[%0t] lxrg mismatch: %s got 0x%08h want 0x%08h", $realtime, what, got, want);
    mismatches++;
  endtask

  // One Park-Miller step, x = 16807 x mod (2^31 - 1), folded without division
  function automatic logic [WORD_W-1:0] pm_advance(input logic [WORD_W-1:0] x);
    logic [PM_PROD_W-1:0] prod;
    logic [31:0]          sum;
    prod = PM_PROD_W'(x) * PM_PROD_W'(PM_MULT);
    sum  = {1'b0, prod[WORD_W-1:0]} + 32'(prod[PM_PROD_W-1:WORD_W]);
    if (sum >= 32'h8000_0000) begin
      sum = sum - PM_MOD;
    end
    return sum[WORD_W-1:0];
  endfunction

  // Advance the pointer and write the XOR of the two tapped words there
  task automatic lag_advance(output logic [WORD_W-1:0] word);
    logic [PTR_W-1:0] p;
    logic [PTR_W-1:0] near_idx;
    logic [PTR_W-1:0] far_idx;
    p         = write_pos + PTR_W'(1);
    near_idx  = p - TAP_NEAR;
    far_idx   = p - TAP_FAR;
    word      = lag_words[near_idx] ^ lag_words[far_idx];
    write_pos = p;
    lag_words[p] = word;
  endtask

  // Discard warm-up steps, fill the table, then run the XOR warm-up
  task automatic reseed_table();
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] scratch;
    x = seed_value;
    repeat (WARMUP_STEPS - 1) x = pm_advance(x);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      x = pm_advance(x);
      lag_words[i] = x;
    end
    write_pos = '0;
    repeat (WARMUP_STEPS + 1) lag_advance(scratch);
  endtask

  always @(posedge clk) begin
    rsp_t              want;
    logic [WORD_W-1:0] word;
    logic [DRAW_PROD_W-1:0] prod;
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) lag_words[i] = '0;
      write_pos  = '0;
      seed_value = SEED_RESET;
      expected_draws.delete();
    end else begin
      if (seed_we) begin
        seed_value = seed_wdata;
      end
      // Compare a result transfer against the oldest prediction
      if (rsp_valid && rsp_ready) begin
        if (expected_draws.size() == 0) begin
          report_mismatch("unexpected result, value", rsp.value, '0);
        end else begin
          want = expected_draws.pop_front();
          if (rsp.value !== want.value) report_mismatch("value", rsp.value, want.value);
          if (rsp.scaled !== want.scaled) report_mismatch("scaled", rsp.scaled, want.scaled);
        end
      end
      // Predict from a request transfer
      if (req_valid && req_ready) begin
        if (req.kind == KIND_RESEED) begin
          reseed_table();
        end else begin
          lag_advance(word);
          prod        = DRAW_PROD_W'(word) * DRAW_PROD_W'(req.range_max);
          want.value  = word;
          want.scaled = prod[DRAW_PROD_W-1:WORD_W];
          expected_draws.push_back(want);
        end
      end
    end
    pending = expected_draws.size();
  end

endmodule

>>> sim/testbench.sv
// Stimulus, idling and verdict for the lagged XOR random generator core.
`timescale 1ns / 1ps
module testbench;
  import lxrg_pkg::*;

  localparam int WARMUP        = 10000;
  localparam int RESEED_CYCLES = 4 * WARMUP + 600;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 250;
  localparam int RESEED_CAP    = 6;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              req_valid  = 1'b0;
  req_t              req        = '0;
  logic              rsp_ready  = 1'b0;
  logic              seed_we    = 1'b0;
  logic [WORD_W-1:0] seed_wdata = '0;
  logic              req_ready;
  logic              rsp_valid;
  rsp_t              rsp;
  int                mismatches;
  int                pending;
  int                cycles     = 0;
  bit                no_idle    = 1'b0;
  bit                reseed_busy = 1'b0;

  always #1 clk = ~clk;

  lagged_xor_random_generator_core #(
    .WARMUP_STEPS(WARMUP)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .seed_we   (seed_we),
    .seed_wdata(seed_wdata)
  );

  lxrg_checker #(
    .WARMUP_STEPS(WARMUP)
  ) checker_i (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .seed_we   (seed_we),
    .seed_wdata(seed_wdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  // Mix of small, full-scale and arbitrary bounds
  function automatic logic [WORD_W-1:0] pick_range();
    unique case ($urandom_range(0, 3))
      0:       return WORD_W'($urandom_range(0, 15));
      1:       return '1;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // Present one request and hold it until its transfer; returns at the next falling edge
  task automatic send(input logic kind, input logic [WORD_W-1:0] range_max);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid     = 1'b1;
    req.kind      = kind;
    req.range_max = range_max;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    reseed_busy = (kind == KIND_RESEED);
    @(negedge clk);
  endtask

  // Drop the request, drain all results and let a trailing reseed finish
  task automatic settle();
    req_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (reseed_busy ? RESEED_CYCLES : 20) @(negedge clk);
    reseed_busy = 1'b0;
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] value);
    seed_we    = 1'b1;
    seed_wdata = value;
    @(negedge clk);
    seed_we    = 1'b0;
  endtask

  // Result side: stall a random number of cycles before each transfer
  initial begin : result_side
    int stall;
    @(negedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        rsp_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready = 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int reseeds;
    reseeds = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Draws on the cleared table give zero
    send(KIND_DRAW, '0);
    send(KIND_DRAW, '1);
    // Reseed from the reset seed value, then the bound extremes
    send(KIND_RESEED, '0);
    send(KIND_DRAW, '0);
    send(KIND_DRAW, 31'd1);
    send(KIND_DRAW, '1);
    send(KIND_DRAW, 31'h4000_0000);
    send(KIND_DRAW, 31'h5555_5555);
    send(KIND_DRAW, 31'h2AAA_AAAA);
    // Zero seed keeps the table at zero
    settle();
    write_seed('0);
    send(KIND_RESEED, '1);
    send(KIND_DRAW, '1);
    send(KIND_DRAW, 31'd7);
    // All-ones seed is a fixed point of the Park-Miller step
    settle();
    write_seed('1);
    send(KIND_RESEED, '0);
    send(KIND_DRAW, '1);
    send(KIND_DRAW, '0);
    send(KIND_DRAW, 31'h0000_FFFF);
    // Smallest and largest legal seeds
    settle();
    write_seed(31'd1);
    send(KIND_RESEED, '0);
    send(KIND_DRAW, '1);
    send(KIND_DRAW, 31'd1000);
    settle();
    write_seed(31'h7FFF_FFFE);
    send(KIND_RESEED, '0);
    send(KIND_DRAW, '1);
    send(KIND_DRAW, 31'h1234_5678);

    // Random phases: new seed, reseed, then mostly draws with rare reseeds
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      write_seed(WORD_W'($urandom));
      send(KIND_RESEED, pick_range());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          no_idle = ($urandom_range(0, 3) == 0);
        end
        if (reseeds < RESEED_CAP && $urandom_range(0, 199) == 0) begin
          reseeds++;
          send(KIND_RESEED, pick_range());
        end else begin
          send(KIND_DRAW, pick_range());
        end
      end
    end

    no_idle = 1'b0;
    settle();
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/lxrg_pkg.sv
hdl/lagged_xor_random_generator_core.sv
sim/lxrg_checker.sv
sim/testbench.sv
